@@ hdl/apm_pkg.sv @@
// Shared types and constants of the audio peak / RMS level meter.
`default_nettype none
package apm_pkg;

  // Default widths for the top-level parameters
  localparam int unsigned DEF_SAMPLE_BITS = 16;
  localparam int unsigned DEF_COUNT_BITS  = 32;

  // Widest accumulator widths that a window request may carry
  localparam int unsigned CNT_W_MAX = 32;
  localparam int unsigned SUM_W_MAX = 30 + CNT_W_MAX;

  // Step counter wide enough for the longest divider run
  localparam int unsigned STEP_W = $clog2(SUM_W_MAX + 1);

  // Floor limits and reset value, Q8.8 dB
  localparam logic signed [15:0] FLOOR_MIN   = -16'sd30720;
  localparam logic signed [15:0] FLOOR_MAX   = -16'sd256;
  localparam logic signed [15:0] FLOOR_RESET = -16'sd30720;

  // 20*log10(2) in Q16
  localparam logic [18:0] DB_K_Q16 = 19'd394566;

  // One closed measurement window, handed from front to back
  typedef struct packed {
    logic [14:0]          max_pos;
    logic [15:0]          max_neg;
    logic [SUM_W_MAX-1:0] sum;
    logic [CNT_W_MAX-1:0] count;
  } win_t;

endpackage
`default_nettype wire

@@ hdl/apm_front.sv @@
// Front end: takes samples, keeps the peaks, square sum and count, closes windows.
`default_nettype none
module apm_front #(
  parameter int unsigned SAMPLE_BITS = 16,
  parameter int unsigned COUNT_BITS  = 32
) (
  input  wire                 clk_i,
  input  wire                 rst_ni,
  input  wire          [15:0] sample_i,
  input  wire                 last_i,
  input  wire                 in_valid_i,
  output logic                in_ready_o,
  input  wire                 q_full_i,
  output logic                push_o,
  output apm_pkg::win_t       push_win_o
);
  import apm_pkg::*;

  localparam int unsigned SUM_W = 30 + COUNT_BITS;

  logic [14:0]            pos_q, pos_d;
  logic [15:0]            neg_q, neg_d;
  logic [SUM_W-1:0]       sum_q, sum_d;
  logic [COUNT_BITS-1:0]  cnt_q, cnt_d;
  logic [SAMPLE_BITS-1:0] raw;
  logic [15:0]            v;
  logic [15:0]            mag;
  logic [31:0]            sq;
  logic                   counting;
  logic                   accept;

  assign in_ready_o = !q_full_i;
  assign accept     = in_valid_i && in_ready_o;

  // Scale the sample to Q1.15 and take its magnitude
  assign raw = sample_i[SAMPLE_BITS-1:0];
  assign v   = 16'(raw) << (16 - SAMPLE_BITS);
  assign mag = v[15] ? (~v + 16'd1) : v;
  assign sq  = 32'(mag) * 32'(mag);

  // Update the peaks, and the sum and count until the count saturates
  assign counting = (cnt_q != '1);
  always_comb begin
    pos_d = (!v[15] && (v[14:0] > pos_q)) ? v[14:0] : pos_q;
    neg_d = (v[15] && (mag > neg_q)) ? mag : neg_q;
    sum_d = counting ? (sum_q + SUM_W'(sq)) : sum_q;
    cnt_d = counting ? (cnt_q + COUNT_BITS'(1)) : cnt_q;
  end

  // Hand the closed window on
  assign push_o             = accept && last_i;
  assign push_win_o.max_pos = pos_d;
  assign push_win_o.max_neg = neg_d;
  assign push_win_o.sum     = SUM_W_MAX'(sum_d);
  assign push_win_o.count   = CNT_W_MAX'(cnt_d);

  // Hold the accumulators, clear them when a window closes
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      pos_q <= '0;
      neg_q <= '0;
      sum_q <= '0;
      cnt_q <= '0;
    end else if (accept) begin
      if (last_i) begin
        pos_q <= '0;
        neg_q <= '0;
        sum_q <= '0;
        cnt_q <= '0;
      end else begin
        pos_q <= pos_d;
        neg_q <= neg_d;
        sum_q <= sum_d;
        cnt_q <= cnt_d;
      end
    end
  end

endmodule
`default_nettype wire

@@ hdl/apm_queue.sv @@
// Two-entry queue of closed windows between front and back.
`default_nettype none
module apm_queue (
  input  wire            clk_i,
  input  wire            rst_ni,
  input  wire            push_i,
  input  apm_pkg::win_t  push_win_i,
  input  wire            pop_i,
  output apm_pkg::win_t  pop_win_o,
  output logic           full_o,
  output logic           empty_o
);
  import apm_pkg::*;

  win_t       mem_q [2];
  logic       wr_q, rd_q;
  logic [1:0] fill_q;

  assign full_o    = (fill_q == 2'd2);
  assign empty_o   = (fill_q == 2'd0);
  assign pop_win_o = mem_q[rd_q];

  // Store pushed windows
  always_ff @(posedge clk_i) begin
    if (push_i) begin
      mem_q[wr_q] <= push_win_i;
    end
  end

  // Advance pointers and fill level
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      wr_q   <= 1'b0;
      rd_q   <= 1'b0;
      fill_q <= 2'd0;
    end else begin
      if (push_i) wr_q <= ~wr_q;
      if (pop_i)  rd_q <= ~rd_q;
      fill_q <= fill_q + 2'(push_i) - 2'(pop_i);
    end
  end

  a_no_overflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    full_o && !pop_i |-> !push_i) else $error("window queue overflow");
  a_no_underflow: assert property (@(posedge clk_i) disable iff (!rst_ni)
    empty_o |-> !pop_i) else $error("window queue underflow");

endmodule
`default_nettype wire

@@ hdl/apm_back.sv @@
// Back end: divide, square root and two dB conversions per window, output register.
`default_nettype none
module apm_back #(
  parameter int unsigned COUNT_BITS = 32
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire         [15:0] cfg_wdata_i,
  input  wire                q_empty_i,
  input  apm_pkg::win_t      pop_win_i,
  output logic               pop_o,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic        [14:0] peak_positive_o,
  output logic        [15:0] peak_negative_mag_o,
  output logic signed [15:0] peak_db_o,
  output logic        [15:0] rms_level_o,
  output logic signed [15:0] rms_db_o,
  output logic        [14:0] crest_db_o,
  output logic        [31:0] sample_total_o
);
  import apm_pkg::*;

  localparam int unsigned SUM_W = 30 + COUNT_BITS;

  typedef enum logic [3:0] {
    S_IDLE, S_DIV, S_SQRT, S_LOG_LOAD, S_LOG_SQ, S_LOG_NORM,
    S_LOG_MUL, S_LOG_RND, S_DONE
  } state_e;

  state_e                state_q;
  logic signed [15:0]    floor_q;
  logic [STEP_W-1:0]     step_q;
  logic [14:0]           pos_q;
  logic [15:0]           neg_q;
  logic [CNT_W_MAX-1:0]  cnt_q;
  logic [SUM_W_MAX-1:0]  dvd_q, quo_q;
  logic [31:0]           rem_q;
  logic [31:0]           n_q, res_q, bit_q;
  logic [15:0]           rms_q;
  logic                  sel_q;
  logic [3:0]            e_q;
  logic [31:0]           m_q;
  logic [63:0]           prod_q;
  logic [15:0]           f_q;
  logic [38:0]           dbp_q;
  logic signed [15:0]    pdb_q, rdb_q;

  // Floor saturated to its legal range
  logic signed [15:0] flr;
  assign flr = (floor_q < FLOOR_MIN) ? FLOOR_MIN :
               (floor_q > FLOOR_MAX) ? FLOOR_MAX : floor_q;

  // Divider step
  logic [32:0] rem_s;
  logic        div_ge;
  assign rem_s  = {rem_q, dvd_q[SUM_W_MAX-1]};
  assign div_ge = (rem_s >= 33'(cnt_q));

  // Square root step
  logic [31:0] trial;
  assign trial = res_q + bit_q;

  // Log input level and its leading one
  logic [15:0] peak, lx;
  logic [3:0]  lead;
  assign peak = (16'(pos_q) > neg_q) ? 16'(pos_q) : neg_q;
  assign lx   = sel_q ? rms_q : peak;
  always_comb begin
    lead = '0;
    for (int i = 1; i < 16; i++) begin
      if (lx[i]) lead = 4'(i);
    end
  end

  // Normalise the squared mantissa
  logic [31:0] mn;
  assign mn = prod_q[61:30];

  // Log magnitude, rounding and floor clamp
  logic [19:0]        lmag;
  logic [39:0]        rnd;
  logic signed [16:0] db17;
  logic signed [15:0] db;
  assign lmag = {4'd15 - e_q, 16'd0} - 20'(f_q);
  assign rnd  = 40'(dbp_q) + 40'h80_0000;
  assign db17 = -$signed({1'b0, rnd[39:24]});
  assign db   = (db17 < 17'(flr)) ? flr : db17[15:0];

  // Crest factor
  logic signed [16:0] crest;
  assign crest = 17'(pdb_q) - 17'(rdb_q);

  assign pop_o = (state_q == S_IDLE) && !q_empty_i;

  // Hold the floor register
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      floor_q <= FLOOR_RESET;
    end else if (cfg_we_i) begin
      floor_q <= cfg_wdata_i;
    end
  end

  // Sequence the window computation and register the result
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q             <= S_IDLE;
      out_valid_o         <= 1'b0;
      step_q              <= '0;
      sel_q               <= 1'b0;
      pos_q               <= '0;
      neg_q               <= '0;
      cnt_q               <= '0;
      dvd_q               <= '0;
      quo_q               <= '0;
      rem_q               <= '0;
      n_q                 <= '0;
      res_q               <= '0;
      bit_q               <= '0;
      rms_q               <= '0;
      e_q                 <= '0;
      m_q                 <= '0;
      prod_q              <= '0;
      f_q                 <= '0;
      dbp_q               <= '0;
      pdb_q               <= '0;
      rdb_q               <= '0;
      peak_positive_o     <= '0;
      peak_negative_mag_o <= '0;
      peak_db_o           <= '0;
      rms_level_o         <= '0;
      rms_db_o            <= '0;
      crest_db_o          <= '0;
      sample_total_o      <= '0;
    end else begin
      case (state_q)
        S_IDLE: begin
          if (!q_empty_i) begin
            pos_q   <= pop_win_i.max_pos;
            neg_q   <= pop_win_i.max_neg;
            cnt_q   <= pop_win_i.count;
            dvd_q   <= pop_win_i.sum << (SUM_W_MAX - SUM_W);
            rem_q   <= '0;
            quo_q   <= '0;
            step_q  <= '0;
            state_q <= S_DIV;
          end
        end
        S_DIV: begin
          rem_q  <= div_ge ? 32'(rem_s - 33'(cnt_q)) : rem_s[31:0];
          quo_q  <= {quo_q[SUM_W_MAX-2:0], div_ge};
          dvd_q  <= dvd_q << 1;
          if (step_q == STEP_W'(SUM_W - 1)) begin
            step_q  <= '0;
            state_q <= S_SQRT;
          end else begin
            step_q <= step_q + STEP_W'(1);
          end
        end
        S_SQRT: begin
          if (step_q == '0) begin
            n_q   <= 32'(quo_q[30:0]);
            res_q <= '0;
            bit_q <= 32'h4000_0000;
            step_q <= step_q + STEP_W'(1);
          end else begin
            if (n_q >= trial) begin
              n_q   <= n_q - trial;
              res_q <= (res_q >> 1) + bit_q;
            end else begin
              res_q <= res_q >> 1;
            end
            bit_q  <= bit_q >> 2;
            if (step_q == STEP_W'(16)) begin
              step_q  <= '0;
              sel_q   <= 1'b0;
              state_q <= S_LOG_LOAD;
            end else begin
              step_q <= step_q + STEP_W'(1);
            end
          end
        end
        S_LOG_LOAD: begin
          if (step_q == '0 && sel_q == 1'b0) rms_q <= res_q[15:0];
          if (step_q == '0 && sel_q == 1'b0) begin
            step_q <= STEP_W'(1);
          end else if (lx == '0) begin
            if (sel_q) rdb_q <= flr;
            else       pdb_q <= flr;
            step_q  <= '0;
            state_q <= sel_q ? S_DONE : S_LOG_LOAD;
            sel_q   <= 1'b1;
          end else begin
            e_q     <= lead;
            m_q     <= 32'(lx) << (5'd30 - 5'(lead));
            f_q     <= '0;
            step_q  <= '0;
            state_q <= S_LOG_SQ;
          end
        end
        S_LOG_SQ: begin
          prod_q  <= 64'(m_q) * 64'(m_q);
          state_q <= S_LOG_NORM;
        end
        S_LOG_NORM: begin
          f_q    <= {f_q[14:0], mn[31]};
          m_q    <= mn[31] ? (mn >> 1) : mn;
          step_q <= step_q + STEP_W'(1);
          state_q <= (step_q == STEP_W'(15)) ? S_LOG_MUL : S_LOG_SQ;
        end
        S_LOG_MUL: begin
          dbp_q   <= 39'(lmag) * 39'(DB_K_Q16);
          state_q <= S_LOG_RND;
        end
        S_LOG_RND: begin
          if (sel_q) rdb_q <= db;
          else       pdb_q <= db;
          step_q  <= '0;
          state_q <= sel_q ? S_DONE : S_LOG_LOAD;
          sel_q   <= 1'b1;
        end
        S_DONE: begin
          if (!out_valid_o || out_ready_i) begin
            peak_positive_o     <= pos_q;
            peak_negative_mag_o <= neg_q;
            peak_db_o           <= pdb_q;
            rms_level_o         <= rms_q;
            rms_db_o            <= rdb_q;
            crest_db_o          <= crest[16] ? 15'd0 : crest[14:0];
            sample_total_o      <= cnt_q;
            sel_q               <= 1'b0;
            state_q             <= S_IDLE;
          end
        end
        default: state_q <= S_IDLE;
      endcase

      // Raise the result flag on load, drop it once the result is taken
      if (state_q == S_DONE && (!out_valid_o || out_ready_i)) begin
        out_valid_o <= 1'b1;
      end else if (out_ready_i) begin
        out_valid_o <= 1'b0;
      end
    end
  end

  a_rms_range: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DONE |-> rms_q <= 16'd32768) else $error("rms out of range");
  a_div_bound: assert property (@(posedge clk_i) disable iff (!rst_ni)
    state_q == S_DIV |-> step_q < STEP_W'(SUM_W)) else $error("divider overran");
  a_no_lost_result: assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_valid_o && !out_ready_i |=> out_valid_o) else $error("result dropped");

endmodule
`default_nettype wire

@@ hdl/audio_peak_rms_level_meter.sv @@
// Top level of the audio peak / RMS level meter.
// Samples (Q1.15) are taken at one per cycle while the
// two-entry window queue has room; a sample with last set closes the window.
// Each closed window is then worked by the back end: bit-serial division
// of 30 + COUNT_BITS quotient bits, a square root and the two dB
// conversions (each of 16 squarings on the shared 32x32 multiplier);
// sampling goes on meanwhile and stalls only when two windows are already
// waiting.
// The result sits in an output register until taken.
`default_nettype none
module audio_peak_rms_level_meter #(
  parameter int unsigned SAMPLE_BITS = apm_pkg::DEF_SAMPLE_BITS,
  parameter int unsigned COUNT_BITS  = apm_pkg::DEF_COUNT_BITS
) (
  input  wire                clk_i,
  input  wire                rst_ni,
  input  wire                cfg_we_i,
  input  wire         [15:0] cfg_wdata_i,
  input  wire                in_valid_i,
  output logic               in_ready_o,
  input  wire         [15:0] sample_i,
  input  wire                last_i,
  output logic               out_valid_o,
  input  wire                out_ready_i,
  output logic        [14:0] peak_positive_o,
  output logic        [15:0] peak_negative_mag_o,
  output logic signed [15:0] peak_db_o,
  output logic        [15:0] rms_level_o,
  output logic signed [15:0] rms_db_o,
  output logic        [14:0] crest_db_o,
  output logic        [31:0] sample_total_o
);
  import apm_pkg::*;

  win_t push_win, pop_win;
  logic push, pop, q_full, q_empty;

  apm_front #(.SAMPLE_BITS(SAMPLE_BITS), .COUNT_BITS(COUNT_BITS)) u_front (
    .clk_i, .rst_ni, .sample_i, .last_i, .in_valid_i, .in_ready_o,
    .q_full_i(q_full), .push_o(push), .push_win_o(push_win)
  );

  apm_queue u_queue (
    .clk_i, .rst_ni, .push_i(push), .push_win_i(push_win), .pop_i(pop),
    .pop_win_o(pop_win), .full_o(q_full), .empty_o(q_empty)
  );

  apm_back #(.COUNT_BITS(COUNT_BITS)) u_back (
    .clk_i, .rst_ni, .cfg_we_i, .cfg_wdata_i, .q_empty_i(q_empty),
    .pop_win_i(pop_win), .pop_o(pop), .out_valid_o, .out_ready_i,
    .peak_positive_o, .peak_negative_mag_o, .peak_db_o, .rms_level_o,
    .rms_db_o, .crest_db_o, .sample_total_o
  );

endmodule
`default_nettype wire
